/* sv/gprd_pkg.sv */
// Package for the radial deadzone conditioner: state types, constants and
// the status record that a stick unit returns to the top level.
// No dependencies.
`default_nettype none

package gprd_pkg;

   localparam logic [14:0] FULL_SCALE = 15'd32767;
   localparam logic [14:0] DEADZONE_RESET = 15'd7849;
   localparam int DIV_STEPS = 15;
   localparam int ROOT_STEPS = 16;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQX,
      ST_SQY,
      ST_ROOT,
      ST_SCALE,
      ST_DEN,
      ST_NUMER,
      ST_CHECK,
      ST_DIV
   } stick_state_type;

   typedef enum logic {
      T_IDLE,
      T_RUN
   } top_state_type;

   typedef enum logic [1:0] {
      LINK_NONE = 2'd0,
      LINK_UP   = 2'd1,
      LINK_DOWN = 2'd2
   } link_type;

   typedef struct packed {
      logic               idle;
      logic signed [15:0] x;
      logic signed [15:0] y;
   } stick_result_type;

endpackage

`default_nettype wire

/* sv/gprd_if.sv */
// Valid/ready channel interfaces for the poll samples and the results.
// No dependencies.
`default_nettype none

interface gprd_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         pad_index;
   logic               pad_connected;
   logic signed [15:0] raw_left_x;
   logic signed [15:0] raw_left_y;
   logic signed [15:0] raw_right_x;
   logic signed [15:0] raw_right_y;
   logic [7:0]         raw_left_trigger;
   logic [7:0]         raw_right_trigger;
   logic [15:0]        button_word;

   modport source (output valid, pad_index, pad_connected, raw_left_x, raw_left_y,
                   raw_right_x, raw_right_y, raw_left_trigger, raw_right_trigger,
                   button_word, input ready);
   modport sink (input valid, pad_index, pad_connected, raw_left_x, raw_left_y,
                 raw_right_x, raw_right_y, raw_left_trigger, raw_right_trigger,
                 button_word, output ready);
endinterface

interface gprd_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         out_pad;
   logic               out_connected;
   logic signed [15:0] left_x;
   logic signed [15:0] left_y;
   logic signed [15:0] right_x;
   logic signed [15:0] right_y;
   logic [7:0]         left_trigger;
   logic [7:0]         right_trigger;
   logic [15:0]        current_buttons;
   logic [15:0]        previous_buttons;
   logic [1:0]         link_event;

   modport source (output valid, out_pad, out_connected, left_x, left_y, right_x,
                   right_y, left_trigger, right_trigger, current_buttons,
                   previous_buttons, link_event, input ready);
   modport sink (input valid, out_pad, out_connected, left_x, left_y, right_x,
                 right_y, left_trigger, right_trigger, current_buttons,
                 previous_buttons, link_event, output ready);
endinterface

`default_nettype wire

/* sv/gamepad_radial_deadzone_conditioner_unit.sv */
// Top level of the radial deadzone conditioner: per-pad state, deadzone
// register and output register. Depends on gprd_pkg, gprd_if and gprd_stick.
//
//   channel  direction  handshake     contents
//   req_if   in         valid/ready   one poll sample of one pad
//   rsp_if   out        valid/ready   conditioned sample, buttons, link event
//   csr_*    in         write enable  deadzone radius, 15 bits
//
// An item's time from acceptance to a valid result is shortest when both
// sticks fall inside the deadzone, set by the squares and the 16-step square
// root, and longest when two 15-step divisions, one per axis, follow in a stick
// unit. Both sticks run in parallel. One item is in work at a time; the next is
// accepted as soon as the result sits in the output register, even while that
// result is not yet taken. A result that is not taken holds back the next one.
// Reset clears the per-pad state and loads the default deadzone.
`default_nettype none

module gamepad_radial_deadzone_conditioner_unit
   import gprd_pkg::*;
#(
   parameter int PAD_COUNT = 4
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   gprd_req_if.sink         req_if,
   gprd_rsp_if.source       rsp_if,
   input  wire logic        csr_write_enable,
   input  wire logic [14:0] csr_write_data
);

   localparam int IDX_W = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;

   top_state_type state_ff, state_in;
   logic [14:0] dz_ff;
   logic [15:0] last_buttons_ff [PAD_COUNT];
   logic        last_connected_ff [PAD_COUNT];

   logic [1:0]  pad_ff;
   logic        conn_ff;
   logic [7:0]  lt_ff, rt_ff;
   logic [15:0] btn_ff, prev_ff;
   logic [1:0]  ev_ff;
   logic        rsp_valid_ff, rsp_valid_in;

   logic accept, finish, pad_ok;
   logic [IDX_W-1:0] pad_idx;
   logic [15:0] prev_in;
   logic [1:0]  ev_in;
   stick_result_type left_res, right_res;

   assign accept = req_if.valid && req_if.ready;
   assign pad_ok = 32'(req_if.pad_index) < PAD_COUNT;
   assign pad_idx = IDX_W'(req_if.pad_index);
   assign finish = (state_ff == T_RUN) && left_res.idle && right_res.idle &&
                   (!rsp_valid_ff || rsp_if.ready);

   gprd_stick left_unit (
      .clock(clock), .reset(reset), .start(accept),
      .x(req_if.raw_left_x), .y(req_if.raw_left_y), .deadzone(dz_ff),
      .result(left_res)
   );

   gprd_stick right_unit (
      .clock(clock), .reset(reset), .start(accept),
      .x(req_if.raw_right_x), .y(req_if.raw_right_y), .deadzone(dz_ff),
      .result(right_res)
   );

   always_comb begin
      prev_in = 16'd0;
      ev_in = LINK_NONE;
      if (pad_ok) begin
         prev_in = last_buttons_ff[pad_idx];
         if (req_if.pad_connected && !last_connected_ff[pad_idx]) begin
            ev_in = LINK_UP;
         end else if (!req_if.pad_connected && last_connected_ff[pad_idx]) begin
            ev_in = LINK_DOWN;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      req_if.ready = 1'b0;
      case (state_ff)
         T_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid) begin
               state_in = T_RUN;
            end
         end
         T_RUN: begin
            if (finish) begin
               rsp_valid_in = 1'b1;
               state_in = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         rsp_valid_ff <= 1'b0;
         dz_ff <= DEADZONE_RESET;
         for (int i = 0; i < PAD_COUNT; i++) begin
            last_buttons_ff[i] <= 16'd0;
            last_connected_ff[i] <= 1'b0;
         end
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            dz_ff <= csr_write_data;
         end
         if (accept && pad_ok) begin
            last_buttons_ff[pad_idx] <= req_if.pad_connected ? req_if.button_word : 16'd0;
            last_connected_ff[pad_idx] <= req_if.pad_connected;
         end
      end
      if (accept) begin
         pad_ff <= req_if.pad_index;
         conn_ff <= req_if.pad_connected;
         lt_ff <= req_if.pad_connected ? req_if.raw_left_trigger : 8'd0;
         rt_ff <= req_if.pad_connected ? req_if.raw_right_trigger : 8'd0;
         btn_ff <= req_if.pad_connected ? req_if.button_word : 16'd0;
         prev_ff <= prev_in;
         ev_ff <= ev_in;
      end
      if (finish) begin
         rsp_if.out_pad <= pad_ff;
         rsp_if.out_connected <= conn_ff;
         rsp_if.left_x <= conn_ff ? left_res.x : 16'sd0;
         rsp_if.left_y <= conn_ff ? left_res.y : 16'sd0;
         rsp_if.right_x <= conn_ff ? right_res.x : 16'sd0;
         rsp_if.right_y <= conn_ff ? right_res.y : 16'sd0;
         rsp_if.left_trigger <= lt_ff;
         rsp_if.right_trigger <= rt_ff;
         rsp_if.current_buttons <= btn_ff;
         rsp_if.previous_buttons <= prev_ff;
         rsp_if.link_event <= ev_ff;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* sv/gprd_stick.sv */
// One stick pair: squares, bit-serial square root and bit-serial divider.
// Depends on gprd_pkg.
`default_nettype none

module gprd_stick
   import gprd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [15:0] x,
   input  wire logic signed [15:0] y,
   input  wire logic [14:0]        deadzone,
   output stick_result_type        result
);

   stick_state_type state_ff, state_in;
   logic [16:0] ux_ff, ux_in, uy_ff, uy_in;
   logic        sx_ff, sx_in, sy_ff, sy_in;
   logic [14:0] d_ff, d_in, num_ff, num_in, den_ff, den_in;
   logic [31:0] n_ff, n_in, root_ff, root_in, bit_ff, bit_in;
   logic [30:0] dv_ff, dv_in;
   logic [44:0] rem_ff, rem_in, dsh_ff, dsh_in;
   logic [14:0] q_ff, q_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        axis_ff, axis_in;
   logic signed [15:0] ox_ff, ox_in, oy_ff, oy_in;

   logic [29:0] mul_a;
   logic [16:0] mul_b;
   logic [46:0] prod;
   logic [32:0] trial;
   logic [15:0] mag;
   logic [16:0] ua;
   logic [29:0] scaled_a;
   logic [14:0] diff;
   logic [14:0] q_done;
   logic signed [15:0] axis_out;

   assign prod = 47'(mul_a) * 47'(mul_b);
   assign mag = root_ff[15:0];
   assign ua = axis_ff ? uy_ff : ux_ff;
   assign scaled_a = 30'({ua[15:0], 15'd0} - 31'(ua));
   assign trial = 33'(root_ff) + 33'(bit_ff);
   assign diff = mag[14:0] - d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      ux_ff <= ux_in;
      uy_ff <= uy_in;
      sx_ff <= sx_in;
      sy_ff <= sy_in;
      d_ff <= d_in;
      num_ff <= num_in;
      den_ff <= den_in;
      n_ff <= n_in;
      root_ff <= root_in;
      bit_ff <= bit_in;
      dv_ff <= dv_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff <= q_in;
      cnt_ff <= cnt_in;
      axis_ff <= axis_in;
      ox_ff <= ox_in;
      oy_ff <= oy_in;
   end

   always_comb begin
      state_in = state_ff;
      ux_in = ux_ff;
      uy_in = uy_ff;
      sx_in = sx_ff;
      sy_in = sy_ff;
      d_in = d_ff;
      num_in = num_ff;
      den_in = den_ff;
      n_in = n_ff;
      root_in = root_ff;
      bit_in = bit_ff;
      dv_in = dv_ff;
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      axis_in = axis_ff;
      ox_in = ox_ff;
      oy_in = oy_ff;
      mul_a = 30'(ux_ff);
      mul_b = ux_ff;
      q_done = {q_ff[13:0], 1'b0};
      axis_out = 16'sd0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ux_in = x[15] ? 17'(-{x[15], x}) : 17'(x);
               uy_in = y[15] ? 17'(-{y[15], y}) : 17'(y);
               sx_in = x[15];
               sy_in = y[15];
               d_in = deadzone;
               ox_in = 16'sd0;
               oy_in = 16'sd0;
               state_in = ST_SQX;
            end
         end
         ST_SQX: begin
            n_in = prod[31:0];
            state_in = ST_SQY;
         end
         ST_SQY: begin
            mul_a = 30'(uy_ff);
            mul_b = uy_ff;
            n_in = n_ff + prod[31:0];
            root_in = 32'd0;
            bit_in = 32'h4000_0000;
            cnt_in = 4'(ROOT_STEPS - 1);
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (33'(n_ff) >= trial) begin
               n_in = n_ff - trial[31:0];
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff - 4'd1;
            if (cnt_ff == 4'd0) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            if (mag < 16'(d_ff) || mag == 16'd0) begin
               state_in = ST_IDLE;
            end else begin
               if (d_ff == FULL_SCALE) begin
                  num_in = 15'd1;
                  den_in = 15'd1;
               end else begin
                  den_in = FULL_SCALE - d_ff;
                  if (mag >= 16'(FULL_SCALE) || diff > FULL_SCALE - d_ff) begin
                     num_in = FULL_SCALE - d_ff;
                  end else begin
                     num_in = diff;
                  end
               end
               state_in = ST_DEN;
            end
         end
         ST_DEN: begin
            mul_a = 30'(mag);
            mul_b = 17'(den_ff);
            dv_in = prod[30:0];
            axis_in = 1'b0;
            state_in = ST_NUMER;
         end
         ST_NUMER: begin
            mul_a = scaled_a;
            mul_b = 17'(num_ff);
            rem_in = prod[44:0];
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (46'(rem_ff) >= {dv_ff, 15'd0}) begin
               axis_out = 16'(FULL_SCALE);
               if (axis_ff) begin
                  oy_in = sy_ff ? -axis_out : axis_out;
                  state_in = ST_IDLE;
               end else begin
                  ox_in = sx_ff ? -axis_out : axis_out;
                  axis_in = 1'b1;
                  state_in = ST_NUMER;
               end
            end else begin
               dsh_in = {dv_ff, 14'd0};
               q_in = 15'd0;
               cnt_in = 4'(DIV_STEPS - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (rem_ff >= dsh_ff) begin
               rem_in = rem_ff - dsh_ff;
               q_done = {q_ff[13:0], 1'b1};
            end
            q_in = q_done;
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff - 4'd1;
            if (cnt_ff == 4'd0) begin
               axis_out = 16'(q_done);
               if (axis_ff) begin
                  oy_in = sy_ff ? -axis_out : axis_out;
                  state_in = ST_IDLE;
               end else begin
                  ox_in = sx_ff ? -axis_out : axis_out;
                  axis_in = 1'b1;
                  state_in = ST_NUMER;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign result.idle = (state_ff == ST_IDLE);
   assign result.x = ox_ff;
   assign result.y = oy_ff;

endmodule

`default_nettype wire
